// File: sv/jsv_pkg.sv
// Package for the JSON scalar validator: status and value type codes,
// character constants and the literal spelling table.
// No dependencies.
package jsv_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CodeW = 2;
    localparam int unsigned PosW  = 3;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [CodeW-1:0] code_t;
    typedef logic [PosW-1:0]  pos_t;

    localparam code_t ST_OK      = 2'd0;
    localparam code_t ST_EXPECT  = 2'd1;
    localparam code_t ST_INVALID = 2'd2;
    localparam code_t ST_NOTSING = 2'd3;

    localparam code_t TY_NULL   = 2'd0;
    localparam code_t TY_FALSE  = 2'd1;
    localparam code_t TY_TRUE   = 2'd2;
    localparam code_t TY_NUMBER = 2'd3;

    localparam byte_t CH_NUL   = 8'h00;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_MINUS = 8'h2D;
    localparam byte_t CH_DOT   = 8'h2E;
    localparam byte_t CH_0     = 8'h30;
    localparam byte_t CH_9     = 8'h39;
    localparam byte_t CH_UE    = 8'h45;
    localparam byte_t CH_LE    = 8'h65;
    localparam byte_t CH_F     = 8'h66;
    localparam byte_t CH_N     = 8'h6E;
    localparam byte_t CH_T     = 8'h74;

    // Length of each literal, indexed by value type.
    function automatic pos_t lit_len(input code_t kind);
        pos_t len;
        case (kind)
            TY_FALSE: len = 3'd5;
            default:  len = 3'd4;
        endcase
        return len;
    endfunction

    // Expected character of a literal at a position; NUL past its end.
    function automatic byte_t lit_char(input code_t kind, input pos_t pos);
        byte_t ch;
        ch = CH_NUL;
        case (kind)
            TY_FALSE:
            begin
                case (pos)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    3'd4:    ch = "e";
                    default: ch = CH_NUL;
                endcase
            end
            TY_TRUE:
            begin
                case (pos)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    3'd3:    ch = "e";
                    default: ch = CH_NUL;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    3'd2:    ch = "l";
                    3'd3:    ch = "l";
                    default: ch = CH_NUL;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// File: sv/json_scalar_validator_unit.sv
// JSON scalar validator: top level, byte-wise recogniser of one JSON scalar.
// Depends on jsv_pkg.
//
// Usage:
//   Text channel (text_valid/text_ready, text_byte) carries one character per
//   transaction; a zero byte ends the text. Leading and trailing whitespace is
//   skipped, and exactly one null, true, false or number must lie between.
//   Result channel (result_valid/result_ready, status, value_type) carries one
//   transaction per text, produced by the zero byte only.
//   Throughput: one byte per cycle while no result waits; each byte is a
//   single state transition. Latency: the result is registered and appears
//   the cycle after the zero byte is taken.
//   A waiting result holds text_ready low until the receiver takes it; with
//   result_ready high the result register is refilled in the same cycle, so
//   bytes and results flow back to back.
//   After an error later bytes are ignored until the terminator, which reports
//   the latched status; value_type is null unless status is ok.
//   Reset (rst_n low, asynchronous) returns to leading whitespace with no
//   result pending. After each terminator the state likewise returns there.
module json_scalar_validator_unit
    import jsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] status,
    output logic [1:0] value_type
);

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_LIT,
        PH_SIGN,
        PH_ZERO,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_EXP,
        PH_EXPSIGN,
        PH_EXPDIG,
        PH_TRAIL,
        PH_ERROR
    } phase_t;

    phase_t phase_reg, phase_next;
    code_t  kind_reg, kind_next;
    pos_t   pos_reg, pos_next;
    code_t  err_reg, err_next;
    code_t  found_reg, found_next;

    logic   out_valid_reg;
    code_t  status_reg, type_reg;

    logic   accept;
    logic   is_ws, is_digit, is_nul, is_exp;
    logic   fin;
    code_t  fin_code;
    code_t  fin_type;
    pos_t   pos_inc;

    assign text_ready   = !out_valid_reg || result_ready;
    assign accept       = text_valid && text_ready;
    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign value_type   = type_reg;

    assign is_nul   = (text_byte == CH_NUL);
    assign is_ws    = (text_byte == CH_SPACE) || (text_byte == CH_TAB)
                   || (text_byte == CH_LF) || (text_byte == CH_CR);
    assign is_digit = (text_byte >= CH_0) && (text_byte <= CH_9);
    assign is_exp   = (text_byte == CH_LE) || (text_byte == CH_UE);
    assign pos_inc  = pos_reg + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        found_next = found_reg;
        fin        = 1'b0;
        fin_code   = err_reg;

        case (phase_reg)
            PH_LEAD:
            begin
                if (is_ws)
                begin
                    phase_next = PH_LEAD;
                end
                else if (is_nul)
                begin
                    fin      = 1'b1;
                    fin_code = ST_EXPECT;
                end
                else if (text_byte == CH_N || text_byte == CH_F || text_byte == CH_T)
                begin
                    kind_next  = (text_byte == CH_N) ? TY_NULL :
                                 (text_byte == CH_F) ? TY_FALSE : TY_TRUE;
                    pos_next   = 3'd1;
                    phase_next = PH_LIT;
                end
                else if (text_byte == CH_MINUS)
                begin
                    phase_next = PH_SIGN;
                end
                else if (text_byte == CH_0)
                begin
                    phase_next = PH_ZERO;
                end
                else if (is_digit)
                begin
                    phase_next = PH_INT;
                end
                else
                begin
                    err_next   = ST_INVALID;
                    phase_next = PH_ERROR;
                end
            end
            PH_LIT:
            begin
                if (pos_reg < lit_len(kind_reg) && !is_nul
                    && text_byte == lit_char(kind_reg, pos_reg))
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= lit_len(kind_reg))
                    begin
                        found_next = kind_reg;
                        phase_next = PH_TRAIL;
                    end
                end
                else
                begin
                    err_next   = ST_INVALID;
                    phase_next = PH_ERROR;
                    fin        = is_nul;
                    fin_code   = ST_INVALID;
                end
            end
            PH_SIGN, PH_DOT, PH_EXP, PH_EXPSIGN:
            begin
                if (phase_reg == PH_SIGN && text_byte == CH_0)
                begin
                    phase_next = PH_ZERO;
                end
                else if (phase_reg == PH_EXP
                         && (text_byte == CH_PLUS || text_byte == CH_MINUS))
                begin
                    phase_next = PH_EXPSIGN;
                end
                else if (is_digit)
                begin
                    phase_next = (phase_reg == PH_SIGN) ? PH_INT :
                                 (phase_reg == PH_DOT)  ? PH_FRAC : PH_EXPDIG;
                end
                else
                begin
                    err_next   = ST_INVALID;
                    phase_next = PH_ERROR;
                    fin        = is_nul;
                    fin_code   = ST_INVALID;
                end
            end
            PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG, PH_TRAIL:
            begin
                if ((phase_reg == PH_INT || phase_reg == PH_FRAC || phase_reg == PH_EXPDIG)
                    && is_digit)
                begin
                    phase_next = phase_reg;
                end
                else if ((phase_reg == PH_ZERO || phase_reg == PH_INT)
                         && text_byte == CH_DOT)
                begin
                    phase_next = PH_DOT;
                end
                else if ((phase_reg == PH_ZERO || phase_reg == PH_INT
                          || phase_reg == PH_FRAC) && is_exp)
                begin
                    phase_next = PH_EXP;
                end
                else
                begin
                    // value complete: terminator, whitespace or a stray byte
                    if (phase_reg != PH_TRAIL)
                    begin
                        found_next = TY_NUMBER;
                    end
                    if (is_nul)
                    begin
                        fin      = 1'b1;
                        fin_code = err_reg;
                    end
                    else if (is_ws)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        err_next   = ST_NOTSING;
                        phase_next = PH_ERROR;
                    end
                end
            end
            PH_ERROR:
            begin
                fin      = is_nul;
                fin_code = err_reg;
            end
            default:
            begin
                err_next   = ST_INVALID;
                phase_next = PH_ERROR;
                fin        = is_nul;
                fin_code   = ST_INVALID;
            end
        endcase

        fin_type = (fin_code == ST_OK) ? found_next : TY_NULL;

        if (fin)
        begin
            phase_next = PH_LEAD;
            kind_next  = TY_NULL;
            pos_next   = '0;
            err_next   = ST_OK;
            found_next = TY_NULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            kind_reg      <= TY_NULL;
            pos_reg       <= '0;
            err_reg       <= ST_OK;
            found_reg     <= TY_NULL;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            type_reg      <= TY_NULL;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                pos_reg   <= pos_next;
                err_reg   <= err_next;
                found_reg <= found_next;
            end
            if (accept && fin)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= fin_code;
                type_reg      <= fin_type;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: tb/json_scalar_validator_unit_tb.sv
// Self-checking testbench for json_scalar_validator_unit: drives texts byte by
// byte, predicts each text's status and value type, and checks every result.
// Depends on jsv_pkg and json_scalar_validator_unit.
module json_scalar_validator_unit_tb;
    import jsv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TARGET_BYTES = 1900;
    localparam int IDLE_PCT     = 35;

    typedef enum logic [3:0] {
        LEAD_WS, IN_LITERAL, AFTER_MINUS, AFTER_ZERO, IN_INT, AFTER_DOT,
        IN_FRAC, AFTER_E, AFTER_ESIGN, IN_EXP, TRAIL_WS, SKIP_ERR
    } scan_phase_t;

    typedef struct packed {
        code_t status;
        code_t value_type;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       text_valid = 1'b0;
    logic       text_ready;
    logic [7:0] text_byte = CH_NUL;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [1:0] status;
    logic [1:0] value_type;

    byte_t    byte_q[$];
    byte_t    txt[$];
    verdict_t verdict_q[$];

    bit text_taken  = 1'b0;
    bit no_idle     = 1'b0;
    bit rx_hold_req = 1'b0;
    bit hold_done   = 1'b0;
    int hold_cnt    = 0;
    int cycles      = 0;
    int mismatches  = 0;
    int bytes_sent  = 0;

    // Predictor state
    scan_phase_t sc_phase = LEAD_WS;
    code_t       sc_kind  = TY_NULL;
    pos_t        sc_pos   = '0;
    code_t       sc_err   = ST_OK;
    code_t       sc_found = TY_NULL;

    string lit_word[3] = '{"null", "false", "true"};
    byte_t ws_char[4]  = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    string tricky      = "0123456789.eE+-";

    json_scalar_validator_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .value_type   (value_type)
    );

    always #1 clk = ~clk;

    function automatic bit is_blank(input byte_t b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic bit is_numeral(input byte_t b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic void latch_error(input code_t code);
        sc_err   = code;
        sc_phase = SKIP_ERR;
    endfunction

    // Byte following a complete value; returns 1 on the terminator.
    function automatic bit close_value(input byte_t b);
        sc_found = (sc_phase == IN_LITERAL || sc_phase == TRAIL_WS) ? sc_found : TY_NUMBER;
        if (b == CH_NUL)
            return 1'b1;
        if (is_blank(b))
            sc_phase = TRAIL_WS;
        else
            latch_error(ST_NOTSING);
        return 1'b0;
    endfunction

    function automatic bit need_digit(input byte_t b, input scan_phase_t nxt);
        if (is_numeral(b))
        begin
            sc_phase = nxt;
            return 1'b0;
        end
        latch_error(ST_INVALID);
        return b == CH_NUL;
    endfunction

    // Advances the predicted scanner by one byte; returns 1 when a result is due.
    function automatic bit scan_byte(input byte_t b, output verdict_t v);
        bit    done;
        int    len;
        done = 1'b0;
        v    = '{ST_OK, TY_NULL};
        case (sc_phase)
            LEAD_WS:
            begin
                if (is_blank(b))
                    done = 1'b0;
                else if (b == CH_NUL)
                begin
                    sc_err = ST_EXPECT;
                    done   = 1'b1;
                end
                else if (b == CH_N || b == CH_F || b == CH_T)
                begin
                    sc_kind  = (b == CH_N) ? TY_NULL : (b == CH_F) ? TY_FALSE : TY_TRUE;
                    sc_pos   = 3'd1;
                    sc_phase = IN_LITERAL;
                end
                else if (b == CH_MINUS)
                    sc_phase = AFTER_MINUS;
                else if (b == CH_0)
                    sc_phase = AFTER_ZERO;
                else if (is_numeral(b))
                    sc_phase = IN_INT;
                else
                    latch_error(ST_INVALID);
            end
            IN_LITERAL:
            begin
                len = lit_word[sc_kind].len();
                if (sc_pos < len && b != CH_NUL && b == byte_t'(lit_word[sc_kind][sc_pos]))
                begin
                    sc_pos = sc_pos + 3'd1;
                    if (sc_pos >= len)
                    begin
                        sc_found = sc_kind;
                        sc_phase = TRAIL_WS;
                    end
                end
                else
                begin
                    latch_error(ST_INVALID);
                    done = (b == CH_NUL);
                end
            end
            AFTER_MINUS:
            begin
                if (b == CH_0)
                    sc_phase = AFTER_ZERO;
                else
                    done = need_digit(b, IN_INT);
            end
            AFTER_ZERO, IN_INT:
            begin
                if (sc_phase == IN_INT && is_numeral(b))
                    done = 1'b0;
                else if (b == CH_DOT)
                    sc_phase = AFTER_DOT;
                else if (b == CH_LE || b == CH_UE)
                    sc_phase = AFTER_E;
                else
                    done = close_value(b);
            end
            AFTER_DOT:
                done = need_digit(b, IN_FRAC);
            IN_FRAC:
            begin
                if (is_numeral(b))
                    done = 1'b0;
                else if (b == CH_LE || b == CH_UE)
                    sc_phase = AFTER_E;
                else
                    done = close_value(b);
            end
            AFTER_E:
            begin
                if (b == CH_PLUS || b == CH_MINUS)
                    sc_phase = AFTER_ESIGN;
                else
                    done = need_digit(b, IN_EXP);
            end
            AFTER_ESIGN:
                done = need_digit(b, IN_EXP);
            IN_EXP:
            begin
                if (!is_numeral(b))
                    done = close_value(b);
            end
            TRAIL_WS:
                done = close_value(b);
            default:
                done = (b == CH_NUL);
        endcase
        if (done)
        begin
            v.status     = sc_err;
            v.value_type = (sc_err == ST_OK) ? sc_found : TY_NULL;
            sc_phase = LEAD_WS;
            sc_kind  = TY_NULL;
            sc_pos   = '0;
            sc_err   = ST_OK;
            sc_found = TY_NULL;
        end
        return done;
    endfunction

    // Monitor: sample handshakes, predict, compare.
    always @(posedge clk)
    begin
        verdict_t v;
        verdict_t want;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("json_scalar_validator_unit regression: fail");
            $finish;
        end
        else if (rst_n)
        begin
            text_taken = text_valid && text_ready;
            if (result_valid && result_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction: status %0d, value_type %0d",
                             $time, status, value_type);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, status);
                        mismatches = mismatches + 1;
                    end
                    if (value_type !== want.value_type)
                    begin
                        $display("%0t: value_type mismatch: expected %0d, actual %0d",
                                 $time, want.value_type, value_type);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (text_taken && scan_byte(text_byte, v))
                verdict_q.push_back(v);
        end
    end

    // Text driver
    always @(negedge clk)
    begin
        if (rst_n && (!text_valid || text_taken))
        begin
            if (byte_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                text_valid <= 1'b1;
                text_byte  <= byte_q.pop_front();
            end
            else
                text_valid <= 1'b0;
        end
    end

    // Result receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (rx_hold_req && !hold_done)
        begin
            result_ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
            result_ready <= rst_n && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            txt.push_back(byte_t'(s[i]));
    endtask

    task automatic add_ws(input int max_n);
        int n;
        n = $urandom_range(0, max_n);
        repeat (n) txt.push_back(ws_char[$urandom_range(0, 3)]);
    endtask

    task automatic add_digits(input int n);
        repeat (n) txt.push_back(byte_t'(CH_0 + $urandom_range(0, 9)));
    endtask

    task automatic add_value();
        int sel;
        sel = $urandom_range(0, 5);
        if (sel < 3)
            add_str(lit_word[sel]);
        else
        begin
            if ($urandom_range(0, 2) == 0)
                txt.push_back(CH_MINUS);
            if ($urandom_range(0, 3) == 0)
                txt.push_back(CH_0);
            else
            begin
                txt.push_back(byte_t'(CH_0 + $urandom_range(1, 9)));
                add_digits($urandom_range(0, 4));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                txt.push_back(CH_DOT);
                add_digits($urandom_range(1, 4));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                txt.push_back($urandom_range(0, 1) ? CH_LE : CH_UE);
                case ($urandom_range(0, 2))
                    0:       txt.push_back(CH_PLUS);
                    1:       txt.push_back(CH_MINUS);
                    default: ;
                endcase
                add_digits($urandom_range(1, 3));
            end
        end
    endtask

    task automatic commit_text();
        foreach (txt[i])
            byte_q.push_back(txt[i]);
        byte_q.push_back(CH_NUL);
        bytes_sent = bytes_sent + txt.size() + 1;
        txt.delete();
    endtask

    task automatic random_text();
        int sel;
        int cut;
        int at;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            add_ws(2);
            add_value();
            add_ws(2);
        end
        else if (sel < 70)
        begin
            add_value();
            cut = $urandom_range(0, txt.size() - 1);
            while (txt.size() > cut)
                void'(txt.pop_back());
        end
        else if (sel < 80)
        begin
            add_ws(1);
            add_value();
            add_ws(1);
            at = $urandom_range(0, txt.size() - 1);
            if ($urandom_range(0, 1))
                txt[at] = byte_t'(tricky[$urandom_range(0, tricky.len() - 1)]);
            else
                txt[at] = byte_t'($urandom_range(1, 255));
        end
        else if (sel < 88)
        begin
            add_value();
            add_ws(2);
            add_value();
        end
        else if (sel < 94)
            add_ws(4);
        else
            repeat ($urandom_range(1, 6)) txt.push_back(byte_t'($urandom_range(1, 255)));
        commit_text();
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || text_valid || verdict_q.size() != 0)
            @(posedge clk);
    endtask

    string directed[] = '{"", " \t\n\r", "null", " true ", "false", "0", "-0", "12",
                          "-1.5e+3", "9.25E-07", "0e5", "01", "0x", "nul", "fals ",
                          "-", "1.", "1e", "1e+", "-a", "x", "null 1", "1.5.", "tru"};

    initial
    begin
        int mark;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            add_str(directed[i]);
            commit_text();
        end
        txt.push_back(8'hFF);
        txt.push_back(8'h80);
        commit_text();
        drain();

        // Receiver holds off while short texts pile up behind the result register
        rx_hold_req = 1'b1;
        repeat (40)
        begin
            add_str($urandom_range(0, 1) ? "7" : "null");
            commit_text();
        end
        while (!hold_done)
            @(posedge clk);
        drain();

        // Stretch with no idling on either side
        no_idle = 1'b1;
        mark = bytes_sent;
        while (bytes_sent < mark + 400)
            random_text();
        drain();
        no_idle = 1'b0;

        while (bytes_sent < TARGET_BYTES)
            random_text();
        drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("json_scalar_validator_unit regression: pass");
        else
            $display("json_scalar_validator_unit regression: fail");
        $finish;
    end

endmodule

// File: files.f
sv/jsv_pkg.sv
sv/json_scalar_validator_unit.sv
tb/json_scalar_validator_unit_tb.sv
